[hw/rtl/tnc_pkg.sv]
// ----------------------------------------------------------------------------
// tnc_pkg
// Shared types and codes for the tagged tree nesting checker.
// ----------------------------------------------------------------------------
package tnc_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned TYPE_W  = 4;
  localparam int unsigned COUNT_W = 31;
  localparam int unsigned STAT_W  = 4;
  localparam int unsigned DEPTH_W = 6;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_BEGIN_COMPOUND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_END_COMPOUND   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BEGIN_LIST     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_END_LIST       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE_VALUE    = 3'd4;

  // Tag type codes
  localparam logic [TYPE_W-1:0] TYPE_NONE        = 4'd0;
  localparam logic [TYPE_W-1:0] TYPE_SCALAR_LAST = 4'd8;
  localparam logic [TYPE_W-1:0] TYPE_LIST        = 4'd9;
  localparam logic [TYPE_W-1:0] TYPE_COMPOUND    = 4'd10;
  localparam logic [TYPE_W-1:0] TYPE_LAST        = 4'd12;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 4'd0,
    ST_CLOSED       = 4'd1,
    ST_NEED_NAME    = 4'd2,
    ST_NEED_UNNAMED = 4'd3,
    ST_MISMATCH     = 4'd4,
    ST_FULL         = 4'd5,
    ST_NOT_COMPOUND = 4'd6,
    ST_NOT_LIST     = 4'd7,
    ST_SHORT        = 4'd8,
    ST_BAD_TYPE     = 4'd9,
    ST_OVERFLOW     = 4'd10
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic               named;
    logic [TYPE_W-1:0]  tag_type;
    logic [COUNT_W-1:0] decl_count;
  } item_t;

  // Current context; also the layout of one stack entry
  typedef struct packed {
    logic               in_list;
    logic [TYPE_W-1:0]  elem_type;
    logic [COUNT_W-1:0] elem_count;
    logic [COUNT_W-1:0] elem_limit;
  } ctx_t;

  // Decision for one event, from the checker logic to the state registers
  typedef struct packed {
    status_t status;
    logic    push;
    logic    pop;
    logic    set_closed;
    logic    ctx_we;
    ctx_t    ctx_new;
    ctx_t    ctx_save;
  } dec_t;

  // Stack status seen by the checker logic
  typedef struct packed {
    logic full;
    logic empty;
  } stk_stat_t;

endpackage

[hw/rtl/tnc_if.sv]
// ----------------------------------------------------------------------------
// tnc_if
// Valid/ready channels for events in and results out.
// ----------------------------------------------------------------------------
interface tnc_in_if;
  logic                         valid;
  logic                         ready;
  logic [tnc_pkg::CMD_W-1:0]    cmd;
  logic                         named;
  logic [tnc_pkg::TYPE_W-1:0]   tag_type;
  logic [tnc_pkg::COUNT_W-1:0]  decl_count;

  modport source (output valid, cmd, named, tag_type, decl_count, input ready);
  modport sink   (input valid, cmd, named, tag_type, decl_count, output ready);
endinterface

interface tnc_out_if;
  logic                         valid;
  logic                         ready;
  logic [tnc_pkg::STAT_W-1:0]   status;
  logic                         done_res;
  logic [tnc_pkg::DEPTH_W-1:0]  depth;

  modport source (output valid, status, done_res, depth, input ready);
  modport sink   (input valid, status, done_res, depth, output ready);
endinterface

[hw/rtl/tagged_tree_nesting_checker.sv]
// ----------------------------------------------------------------------------
// tagged_tree_nesting_checker
// Validates begin/end/write events of a nested tagged tree, one result each.
// ----------------------------------------------------------------------------
// Path: each event is held in the input register, then checked and its result
//   registered in the result register; a stalled result channel holds it back.
// Throughput: one event per cycle while the result channel is not stalled; the
//   context and top-of-stack registers close the check-update loop per event.
// Reset: synchronous, active low; empty stack, root compound context, no
//   stack clearing pass needed; input not ready while in reset.
module tagged_tree_nesting_checker #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  tnc_in_if.sink           in_s,
  tnc_out_if.source        out_s
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  tnc_pkg::item_t      item_r;
  logic                item_v_r;
  tnc_pkg::ctx_t       ctx_r;
  logic                closed_r;
  logic                out_v_r;
  tnc_pkg::status_t    status_r;
  logic                done_r;
  logic [tnc_pkg::DEPTH_W-1:0] depth_r;

  tnc_pkg::dec_t       dec;
  tnc_pkg::ctx_t       top;
  tnc_pkg::stk_stat_t  stk;
  logic [SPW-1:0]      sp_nxt;
  logic                fire;
  logic                closed_nxt;

  assign fire       = item_v_r && (!out_v_r || out_s.ready);
  assign in_s.ready = rst_n && (!item_v_r || fire);
  assign closed_nxt = closed_r || dec.set_closed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_s.ready) begin
      item_v_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      item_r.cmd        <= in_s.cmd;
      item_r.named      <= in_s.named;
      item_r.tag_type   <= in_s.tag_type;
      item_r.decl_count <= in_s.decl_count;
    end
  end

  tnc_check u_check (
    .item   (item_r),
    .ctx    (ctx_r),
    .closed (closed_r),
    .stk    (stk),
    .top    (top),
    .dec    (dec)
  );

  tnc_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire && dec.push),
    .pop       (fire && dec.pop),
    .push_data (dec.ctx_save),
    .top       (top),
    .stat      (stk),
    .sp_nxt    (sp_nxt)
  );

  // Context update; a failing event leaves it unchanged
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r    <= '0;
      closed_r <= 1'b0;
    end else if (fire) begin
      if (dec.ctx_we) begin
        ctx_r <= dec.ctx_new;
      end
      closed_r <= closed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_s.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= dec.status;
      done_r   <= closed_nxt;
      depth_r  <= tnc_pkg::DEPTH_W'(sp_nxt);
    end
  end

  assign out_s.valid    = out_v_r;
  assign out_s.status   = status_r;
  assign out_s.done_res = done_r;
  assign out_s.depth    = depth_r;

endmodule

[hw/rtl/tnc_check.sv]
// ----------------------------------------------------------------------------
// tnc_check
// Checks one event against the current context and decides the state update.
// ----------------------------------------------------------------------------
module tnc_check (
  input  tnc_pkg::item_t     item,
  input  tnc_pkg::ctx_t      ctx,
  input  logic               closed,
  input  tnc_pkg::stk_stat_t stk,
  input  tnc_pkg::ctx_t      top,
  output tnc_pkg::dec_t      dec
);

  logic                        will_push;
  logic [tnc_pkg::TYPE_W-1:0]  cmp_type;
  tnc_pkg::status_t            tag_st;
  tnc_pkg::ctx_t               adv;
  logic                        list_type_ok;
  logic                        value_type_ok;

  assign will_push = (item.cmd != tnc_pkg::CMD_WRITE_VALUE);

  always_comb begin
    case (item.cmd)
      tnc_pkg::CMD_BEGIN_COMPOUND: cmp_type = tnc_pkg::TYPE_COMPOUND;
      tnc_pkg::CMD_BEGIN_LIST:     cmp_type = tnc_pkg::TYPE_LIST;
      default:                     cmp_type = item.tag_type;
    endcase
  end

  assign list_type_ok  = (item.tag_type != tnc_pkg::TYPE_NONE) &&
                         (item.tag_type <= tnc_pkg::TYPE_LAST);
  assign value_type_ok = list_type_ok &&
                         (item.tag_type != tnc_pkg::TYPE_LIST) &&
                         (item.tag_type != tnc_pkg::TYPE_COMPOUND);

  // Tag rule checks, in priority order
  always_comb begin
    if (closed) begin
      tag_st = tnc_pkg::ST_CLOSED;
    end else if (!ctx.in_list && !item.named) begin
      tag_st = tnc_pkg::ST_NEED_NAME;
    end else if (ctx.in_list && item.named) begin
      tag_st = tnc_pkg::ST_NEED_UNNAMED;
    end else if (ctx.in_list && (cmp_type != ctx.elem_type)) begin
      tag_st = tnc_pkg::ST_MISMATCH;
    end else if (ctx.in_list && (ctx.elem_count >= ctx.elem_limit)) begin
      tag_st = tnc_pkg::ST_FULL;
    end else if (will_push && stk.full) begin
      tag_st = tnc_pkg::ST_OVERFLOW;
    end else begin
      tag_st = tnc_pkg::ST_OK;
    end
  end

  // Parent context with its list count advanced for the new tag
  always_comb begin
    adv = ctx;
    if (ctx.in_list) begin
      adv.elem_count = ctx.elem_count + tnc_pkg::COUNT_W'(1);
    end
  end

  always_comb begin
    dec            = '0;
    dec.status     = tnc_pkg::ST_OK;
    dec.ctx_new    = ctx;
    dec.ctx_save   = adv;
    unique case (item.cmd)
      tnc_pkg::CMD_BEGIN_COMPOUND: begin
        dec.status = tag_st;
        if (tag_st == tnc_pkg::ST_OK) begin
          dec.push            = 1'b1;
          dec.ctx_we          = 1'b1;
          dec.ctx_new         = adv;
          dec.ctx_new.in_list = 1'b0;
        end
      end
      tnc_pkg::CMD_END_COMPOUND: begin
        if (closed || ctx.in_list) begin
          dec.status = tnc_pkg::ST_NOT_COMPOUND;
        end else if (stk.empty) begin
          dec.set_closed = 1'b1;
        end else begin
          dec.pop     = 1'b1;
          dec.ctx_we  = 1'b1;
          dec.ctx_new = top;
        end
      end
      tnc_pkg::CMD_BEGIN_LIST: begin
        if (!list_type_ok) begin
          dec.status = tnc_pkg::ST_BAD_TYPE;
        end else begin
          dec.status = tag_st;
          if (tag_st == tnc_pkg::ST_OK) begin
            dec.push               = 1'b1;
            dec.ctx_we             = 1'b1;
            dec.ctx_new.in_list    = 1'b1;
            dec.ctx_new.elem_type  = item.tag_type;
            dec.ctx_new.elem_count = '0;
            dec.ctx_new.elem_limit = item.decl_count;
          end
        end
      end
      tnc_pkg::CMD_END_LIST: begin
        if (closed || !ctx.in_list) begin
          dec.status = tnc_pkg::ST_NOT_LIST;
        end else if (ctx.elem_count < ctx.elem_limit) begin
          dec.status = tnc_pkg::ST_SHORT;
        end else if (stk.empty) begin
          dec.set_closed = 1'b1;
        end else begin
          dec.pop     = 1'b1;
          dec.ctx_we  = 1'b1;
          dec.ctx_new = top;
        end
      end
      tnc_pkg::CMD_WRITE_VALUE: begin
        if (!value_type_ok) begin
          dec.status = tnc_pkg::ST_BAD_TYPE;
        end else begin
          dec.status = tag_st;
          if (tag_st == tnc_pkg::ST_OK) begin
            dec.ctx_we  = 1'b1;
            dec.ctx_new = adv;
          end
        end
      end
      default: begin
        dec.status = tnc_pkg::ST_BAD_TYPE;
      end
    endcase
  end

endmodule

[hw/rtl/tnc_stack.sv]
// ----------------------------------------------------------------------------
// tnc_stack
// Context stack: top entry in a register, every entry also in a memory whose
// registered read port always holds the entry below the top.
// ----------------------------------------------------------------------------
module tnc_stack #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic                             pop,
  input  tnc_pkg::ctx_t                    push_data,
  output tnc_pkg::ctx_t                    top,
  output tnc_pkg::stk_stat_t               stat,
  output logic [$clog2(STACK_DEPTH+1)-1:0] sp_nxt
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  tnc_pkg::ctx_t  mem [STACK_DEPTH];
  tnc_pkg::ctx_t  top_r;
  tnc_pkg::ctx_t  below_r;
  logic [SPW-1:0] sp_r;
  logic [SPW-1:0] rd_ptr;

  always_comb begin
    if (push) begin
      sp_nxt = sp_r + SPW'(1);
    end else if (pop) begin
      sp_nxt = sp_r - SPW'(1);
    end else begin
      sp_nxt = sp_r;
    end
  end

  // Entry two below the next pointer is the one below the next top
  assign rd_ptr = sp_nxt - SPW'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[sp_r[AW-1:0]] <= push_data;
    end
    below_r <= mem[rd_ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      top_r <= push_data;
    end else if (pop) begin
      top_r <= below_r;
    end
  end

  assign top        = top_r;
  assign stat.full  = (sp_r == SPW'(STACK_DEPTH));
  assign stat.empty = (sp_r == '0);

endmodule

[hw/rtl/tnc_sva.sv]
// ----------------------------------------------------------------------------
// tnc_sva
// Port-level checks on the result channel of the nesting checker.
// ----------------------------------------------------------------------------
module tnc_sva (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tnc_pkg::STAT_W-1:0]   status,
  input logic                         done_res,
  input logic [tnc_pkg::DEPTH_W-1:0]  depth
);

  logic seen_done_r;

  // Remember that a delivered result reported the root closed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_done_r <= 1'b0;
    end else if (out_valid && out_ready && done_res) begin
      seen_done_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(done_res) && $stable(depth))
    else $error("result changed while stalled");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_done_r |-> done_res)
    else $error("done flag cleared after root was closed");

  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> depth == '0)
    else $error("closed root with non-empty stack");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status <= tnc_pkg::ST_OVERFLOW)
    else $error("status code out of range");

endmodule

bind tagged_tree_nesting_checker tnc_sva u_tnc_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .status    (out_s.status),
  .done_res  (out_s.done_res),
  .depth     (out_s.depth)
);

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Regression for the tagged tree nesting checker. Events go in on a
// valid/ready channel with bursty gaps, and results are taken under a
// changing stall pattern. A shadow of the nesting context and saved-context
// stack predicts status, done flag and depth for every accepted event.
// Directed tests cover the naming, type, size and ordering rules. Random
// traffic is mostly well-formed trees with some malformed events mixed in.
// Later tests cover stack overflow and the events that follow closing the
// root.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NEST_MAX       = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_EVENTS  = 1300;

  localparam logic [tnc_pkg::TYPE_W-1:0] TYPE_BYTE      = 4'd1;
  localparam logic [tnc_pkg::TYPE_W-1:0] TYPE_INT       = 4'd3;
  localparam logic [tnc_pkg::TYPE_W-1:0] TYPE_LONG      = 4'd4;
  localparam logic [tnc_pkg::TYPE_W-1:0] TYPE_INT_ARRAY = 4'd11;
  localparam logic [tnc_pkg::TYPE_W-1:0] TYPE_RSVD_MIN  = 4'd13;
  localparam logic [tnc_pkg::TYPE_W-1:0] TYPE_RSVD_MAX  = 4'd15;
  localparam logic [tnc_pkg::CMD_W-1:0]  CMD_FIRST_UNUSED = 3'd5;

  typedef struct packed {
    tnc_pkg::status_t             status;
    logic                         done_res;
    logic [tnc_pkg::DEPTH_W-1:0]  depth;
  } verdict_t;

  typedef enum int {RX_STREAM, RX_LIGHT, RX_HEAVY} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  tnc_in_if  ev_ch ();
  tnc_out_if res_ch ();

  tagged_tree_nesting_checker #(
    .STACK_DEPTH(NEST_MAX)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (ev_ch),
    .out_s (res_ch)
  );

  always #2 clk = ~clk;

  // Shadow of the nesting state
  tnc_pkg::ctx_t cur_ctx;
  tnc_pkg::ctx_t saved_ctx [NEST_MAX];
  logic          tree_closed;
  int            nest_level;

  verdict_t verdicts_due [$];
  verdict_t due_verdict;
  int       err_count;
  int       burst_left;
  int       quiet_cycles;
  rx_mode_e rx_mode;
  int       rx_span;

  function automatic tnc_pkg::status_t admit_tag(logic named,
                                                 logic [tnc_pkg::TYPE_W-1:0] ttype,
                                                 logic pushes);
    if (tree_closed) return tnc_pkg::ST_CLOSED;
    if (!cur_ctx.in_list) begin
      if (!named) return tnc_pkg::ST_NEED_NAME;
    end else begin
      if (named) return tnc_pkg::ST_NEED_UNNAMED;
      if (ttype != cur_ctx.elem_type) return tnc_pkg::ST_MISMATCH;
      if (cur_ctx.elem_count >= cur_ctx.elem_limit) return tnc_pkg::ST_FULL;
    end
    if (pushes && nest_level >= NEST_MAX) return tnc_pkg::ST_OVERFLOW;
    // the parent's count includes the new child before it is saved
    if (cur_ctx.in_list) cur_ctx.elem_count = cur_ctx.elem_count + 1'b1;
    return tnc_pkg::ST_OK;
  endfunction

  function automatic void push_ctx();
    saved_ctx[nest_level] = cur_ctx;
    nest_level++;
  endfunction

  function automatic void pop_ctx();
    if (nest_level == 0) begin
      tree_closed = 1'b1;
    end else begin
      nest_level--;
      cur_ctx = saved_ctx[nest_level];
    end
  endfunction

  function automatic verdict_t judge_event(tnc_pkg::item_t ev);
    tnc_pkg::status_t st;
    verdict_t         v;
    st = tnc_pkg::ST_OK;
    case (ev.cmd)
      tnc_pkg::CMD_BEGIN_COMPOUND: begin
        st = admit_tag(ev.named, tnc_pkg::TYPE_COMPOUND, 1'b1);
        if (st == tnc_pkg::ST_OK) begin
          push_ctx();
          cur_ctx.in_list = 1'b0;
        end
      end
      tnc_pkg::CMD_END_COMPOUND: begin
        if (tree_closed || cur_ctx.in_list) st = tnc_pkg::ST_NOT_COMPOUND;
        else pop_ctx();
      end
      tnc_pkg::CMD_BEGIN_LIST: begin
        if (ev.tag_type == tnc_pkg::TYPE_NONE || ev.tag_type > tnc_pkg::TYPE_LAST) begin
          st = tnc_pkg::ST_BAD_TYPE;
        end else begin
          st = admit_tag(ev.named, tnc_pkg::TYPE_LIST, 1'b1);
          if (st == tnc_pkg::ST_OK) begin
            push_ctx();
            cur_ctx.in_list    = 1'b1;
            cur_ctx.elem_type  = ev.tag_type;
            cur_ctx.elem_count = '0;
            cur_ctx.elem_limit = ev.decl_count;
          end
        end
      end
      tnc_pkg::CMD_END_LIST: begin
        if (tree_closed || !cur_ctx.in_list) st = tnc_pkg::ST_NOT_LIST;
        else if (cur_ctx.elem_count < cur_ctx.elem_limit) st = tnc_pkg::ST_SHORT;
        else pop_ctx();
      end
      tnc_pkg::CMD_WRITE_VALUE: begin
        if (ev.tag_type == tnc_pkg::TYPE_NONE || ev.tag_type == tnc_pkg::TYPE_LIST ||
            ev.tag_type == tnc_pkg::TYPE_COMPOUND || ev.tag_type > tnc_pkg::TYPE_LAST) begin
          st = tnc_pkg::ST_BAD_TYPE;
        end else begin
          st = admit_tag(ev.named, ev.tag_type, 1'b0);
        end
      end
      default: st = tnc_pkg::ST_BAD_TYPE;
    endcase
    v.status   = st;
    v.done_res = tree_closed;
    v.depth    = nest_level[tnc_pkg::DEPTH_W-1:0];
    return v;
  endfunction

  function automatic tnc_pkg::item_t make_event(logic [tnc_pkg::CMD_W-1:0] cmd, logic named,
                                                logic [tnc_pkg::TYPE_W-1:0] ttype,
                                                logic [tnc_pkg::COUNT_W-1:0] size);
    tnc_pkg::item_t ev;
    ev.cmd        = cmd;
    ev.named      = named;
    ev.tag_type   = ttype;
    ev.decl_count = size;
    return ev;
  endfunction

  // Mostly well-formed events for the current context, some malformed ones
  function automatic tnc_pkg::item_t next_random_event();
    tnc_pkg::item_t             ev;
    logic [31:0]                rnd;
    logic [31:0]                rnd2;
    logic [tnc_pkg::TYPE_W-1:0] vt;
    int unsigned                pick;
    rnd  = $urandom;
    rnd2 = $urandom;
    ev.decl_count = rnd[tnc_pkg::COUNT_W-1:0];
    ev.cmd        = rnd2[tnc_pkg::CMD_W-1:0];
    ev.named      = rnd2[tnc_pkg::CMD_W];
    ev.tag_type   = rnd2[tnc_pkg::CMD_W+tnc_pkg::TYPE_W:tnc_pkg::CMD_W+1];
    vt = tnc_pkg::TYPE_W'($urandom_range(1, 10));
    if (vt > tnc_pkg::TYPE_SCALAR_LAST) vt = vt + 4'd2;
    if ($urandom_range(99) < 20) begin
      if ($urandom_range(1) == 1) ev.decl_count = tnc_pkg::COUNT_W'($urandom_range(0, 6));
      // keep the root open and keep the tree closable
      if (ev.cmd == tnc_pkg::CMD_END_COMPOUND && nest_level == 0 && !cur_ctx.in_list)
        ev.cmd = tnc_pkg::CMD_WRITE_VALUE;
      if ((ev.cmd == tnc_pkg::CMD_BEGIN_COMPOUND || ev.cmd == tnc_pkg::CMD_BEGIN_LIST) &&
          (nest_level >= NEST_MAX - 2 ||
           (ev.cmd == tnc_pkg::CMD_BEGIN_LIST && ev.decl_count > 16)))
        ev.named = cur_ctx.in_list;
    end else if (!cur_ctx.in_list) begin
      pick = $urandom_range(99);
      if (nest_level < NEST_MAX - 2 && pick < 15) begin
        ev.cmd   = tnc_pkg::CMD_BEGIN_COMPOUND;
        ev.named = 1'b1;
      end else if (nest_level < NEST_MAX - 2 && pick < 32) begin
        ev.cmd        = tnc_pkg::CMD_BEGIN_LIST;
        ev.named      = 1'b1;
        ev.tag_type   = tnc_pkg::TYPE_W'($urandom_range(1, tnc_pkg::TYPE_LAST));
        ev.decl_count = tnc_pkg::COUNT_W'($urandom_range(0, 5));
      end else if (nest_level > 0 && pick < 55) begin
        ev.cmd = tnc_pkg::CMD_END_COMPOUND;
      end else begin
        ev.cmd      = tnc_pkg::CMD_WRITE_VALUE;
        ev.named    = 1'b1;
        ev.tag_type = vt;
      end
    end else if (cur_ctx.elem_count >= cur_ctx.elem_limit || $urandom_range(19) == 0) begin
      ev.cmd = tnc_pkg::CMD_END_LIST;
    end else begin
      ev.named    = 1'b0;
      ev.tag_type = cur_ctx.elem_type;
      if (cur_ctx.elem_type == tnc_pkg::TYPE_COMPOUND) begin
        ev.cmd = (nest_level < NEST_MAX - 2) ? tnc_pkg::CMD_BEGIN_COMPOUND :
                                               tnc_pkg::CMD_END_LIST;
      end else if (cur_ctx.elem_type == tnc_pkg::TYPE_LIST) begin
        ev.cmd        = (nest_level < NEST_MAX - 2) ? tnc_pkg::CMD_BEGIN_LIST :
                                                      tnc_pkg::CMD_END_LIST;
        ev.tag_type   = tnc_pkg::TYPE_W'($urandom_range(1, tnc_pkg::TYPE_LAST));
        ev.decl_count = tnc_pkg::COUNT_W'($urandom_range(0, 3));
      end else begin
        ev.cmd = tnc_pkg::CMD_WRITE_VALUE;
      end
    end
    return ev;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_event(input tnc_pkg::item_t ev);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      if (gap > 0) begin
        ev_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    ev_ch.valid      <= 1'b1;
    ev_ch.cmd        <= ev.cmd;
    ev_ch.named      <= ev.named;
    ev_ch.tag_type   <= ev.tag_type;
    ev_ch.decl_count <= ev.decl_count;
    @(posedge clk);
    while (!ev_ch.ready) @(posedge clk);
    verdicts_due.push_back(judge_event(ev));
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    ev_ch.valid <= 1'b0;
    burst_left = 0;
    while (verdicts_due.size() != 0) @(negedge clk);
  endtask

  // Fill and end every open level down to the root
  task automatic close_open_levels();
    while (nest_level > 0) begin
      if (!cur_ctx.in_list) begin
        send_event(make_event(tnc_pkg::CMD_END_COMPOUND, 1'b0, tnc_pkg::TYPE_NONE, '0));
      end else if (cur_ctx.elem_count >= cur_ctx.elem_limit) begin
        send_event(make_event(tnc_pkg::CMD_END_LIST, 1'b0, tnc_pkg::TYPE_NONE, '0));
      end else if (cur_ctx.elem_type == tnc_pkg::TYPE_COMPOUND) begin
        send_event(make_event(tnc_pkg::CMD_BEGIN_COMPOUND, 1'b0, tnc_pkg::TYPE_NONE, '0));
        send_event(make_event(tnc_pkg::CMD_END_COMPOUND, 1'b0, tnc_pkg::TYPE_NONE, '0));
      end else if (cur_ctx.elem_type == tnc_pkg::TYPE_LIST) begin
        send_event(make_event(tnc_pkg::CMD_BEGIN_LIST, 1'b0, TYPE_BYTE, '0));
        send_event(make_event(tnc_pkg::CMD_END_LIST, 1'b0, tnc_pkg::TYPE_NONE, '0));
      end else begin
        send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b0, cur_ctx.elem_type, '0));
      end
    end
  endtask

  task automatic test_directed_rules();
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b1, TYPE_BYTE, '0));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b0, TYPE_BYTE, '1));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b1, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b1, tnc_pkg::TYPE_LIST, '0));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b1, tnc_pkg::TYPE_COMPOUND, '0));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b1, TYPE_RSVD_MAX, '0));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b1, tnc_pkg::TYPE_LAST, '0));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b1, TYPE_INT_ARRAY, '0));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b1, tnc_pkg::TYPE_SCALAR_LAST, '0));
    for (int c = CMD_FIRST_UNUSED; c < (1 << tnc_pkg::CMD_W); c++)
      send_event(make_event(tnc_pkg::CMD_W'(c), 1'b1, TYPE_BYTE, '0));
    send_event(make_event(tnc_pkg::CMD_END_LIST, 1'b1, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_BEGIN_LIST, 1'b1, tnc_pkg::TYPE_NONE, 31'd2));
    send_event(make_event(tnc_pkg::CMD_BEGIN_LIST, 1'b1, TYPE_RSVD_MIN, 31'd2));
    // list of two ints: name rule, type rule, short and full
    send_event(make_event(tnc_pkg::CMD_BEGIN_LIST, 1'b1, TYPE_INT, 31'd2));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b0, TYPE_INT, '0));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b1, TYPE_INT, '0));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b0, TYPE_LONG, '0));
    send_event(make_event(tnc_pkg::CMD_END_LIST, 1'b0, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_END_COMPOUND, 1'b0, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b0, TYPE_INT, '0));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b0, TYPE_INT, '0));
    send_event(make_event(tnc_pkg::CMD_BEGIN_COMPOUND, 1'b0, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_END_LIST, 1'b0, tnc_pkg::TYPE_NONE, '0));
    // empty list of compounds rejects a child
    send_event(make_event(tnc_pkg::CMD_BEGIN_LIST, 1'b1, tnc_pkg::TYPE_COMPOUND, '0));
    send_event(make_event(tnc_pkg::CMD_BEGIN_COMPOUND, 1'b0, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_END_LIST, 1'b0, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_BEGIN_LIST, 1'b0, tnc_pkg::TYPE_LAST, '1));
    send_event(make_event(tnc_pkg::CMD_BEGIN_COMPOUND, 1'b1, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_BEGIN_COMPOUND, 1'b0, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_END_COMPOUND, 1'b0, tnc_pkg::TYPE_NONE, '0));
  endtask

  task automatic test_random_nesting();
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n == RANDOM_EVENTS / 2) hold_until_drained();
      send_event(next_random_event());
    end
  endtask

  task automatic test_stack_overflow();
    close_open_levels();
    send_event(make_event(tnc_pkg::CMD_BEGIN_COMPOUND, 1'b1, tnc_pkg::TYPE_NONE, '0));
    for (int lvl = 0; lvl < (NEST_MAX - 2) / 2; lvl++) begin
      send_event(make_event(tnc_pkg::CMD_BEGIN_LIST, 1'b1, tnc_pkg::TYPE_COMPOUND, 31'd1));
      send_event(make_event(tnc_pkg::CMD_BEGIN_COMPOUND, 1'b0, tnc_pkg::TYPE_NONE, '0));
    end
    // top level of the stack as a list, then as a compound
    send_event(make_event(tnc_pkg::CMD_BEGIN_LIST, 1'b1, TYPE_INT, 31'd1));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b0, TYPE_INT, '0));
    send_event(make_event(tnc_pkg::CMD_END_LIST, 1'b0, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_BEGIN_COMPOUND, 1'b1, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_BEGIN_COMPOUND, 1'b1, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_BEGIN_LIST, 1'b1, TYPE_LONG, 31'd2));
    send_event(make_event(tnc_pkg::CMD_BEGIN_LIST, 1'b1, TYPE_RSVD_MAX, 31'd2));
    send_event(make_event(tnc_pkg::CMD_BEGIN_COMPOUND, 1'b0, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b1, TYPE_INT_ARRAY, '0));
    close_open_levels();
  endtask

  task automatic test_root_close();
    close_open_levels();
    send_event(make_event(tnc_pkg::CMD_END_COMPOUND, 1'b0, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_BEGIN_COMPOUND, 1'b1, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b1, TYPE_BYTE, '0));
    send_event(make_event(tnc_pkg::CMD_WRITE_VALUE, 1'b1, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_BEGIN_LIST, 1'b1, TYPE_INT, 31'd1));
    send_event(make_event(tnc_pkg::CMD_BEGIN_LIST, 1'b1, TYPE_RSVD_MIN, 31'd1));
    send_event(make_event(tnc_pkg::CMD_END_COMPOUND, 1'b0, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(tnc_pkg::CMD_END_LIST, 1'b0, tnc_pkg::TYPE_NONE, '0));
    send_event(make_event(CMD_FIRST_UNUSED, 1'b1, TYPE_BYTE, '0));
  endtask

  // Result receiver: switch stall pattern after a randomly chosen span
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_e'($urandom_range(2));
      rx_span = $urandom_range(20, 300);
    end
    rx_span--;
    case (rx_mode)
      RX_STREAM: res_ch.ready <= 1'b1;
      RX_LIGHT:  res_ch.ready <= ($urandom_range(3) != 0);
      default:   res_ch.ready <= ($urandom_range(3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("result with no pending event: status %0d done %0d depth %0d",
               res_ch.status, res_ch.done_res, res_ch.depth);
        err_count++;
      end else begin
        due_verdict = verdicts_due.pop_front();
        if (res_ch.status !== due_verdict.status) begin
          $error("status mismatch: expected %0d, actual %0d", due_verdict.status, res_ch.status);
          err_count++;
        end
        if (res_ch.done_res !== due_verdict.done_res) begin
          $error("done_res mismatch: expected %0d, actual %0d",
                 due_verdict.done_res, res_ch.done_res);
          err_count++;
        end
        if (res_ch.depth !== due_verdict.depth) begin
          $error("depth mismatch: expected %0d, actual %0d", due_verdict.depth, res_ch.depth);
          err_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tagged_tree_nesting_checker regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    ev_ch.valid        = 1'b0;
    ev_ch.cmd          = '0;
    ev_ch.named        = 1'b0;
    ev_ch.tag_type     = '0;
    ev_ch.decl_count   = '0;
    res_ch.ready       = 1'b0;
    cur_ctx            = '0;
    tree_closed        = 1'b0;
    nest_level         = 0;
    err_count          = 0;
    burst_left         = 0;
    quiet_cycles       = 0;
    rx_mode            = RX_STREAM;
    rx_span            = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_rules();
    test_random_nesting();
    test_stack_overflow();
    test_root_close();
    hold_until_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0 && verdicts_due.size() == 0) begin
      $display("tagged_tree_nesting_checker regression: pass");
    end else begin
      $display("tagged_tree_nesting_checker regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/tnc_pkg.sv
hw/rtl/tnc_if.sv
hw/rtl/tnc_check.sv
hw/rtl/tnc_stack.sv
hw/rtl/tagged_tree_nesting_checker.sv
hw/rtl/tnc_sva.sv
sim/tb_top.sv
